// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
// Both expect signals named clk and arst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with a generic failure message.
`define PSLR_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// Clocked assertion with a caller supplied message.
`define PSLR_ASSERT_MSG(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

// ----- design/pslr_pkg.sv -----
// ----------------------------------------------------------------------------
// pslr_pkg
// Shared types and constants of the PWM speed level ramp block.
// ----------------------------------------------------------------------------
package pslr_pkg;

	localparam int LEVEL_W    = 3;
	localparam int TARGET_W   = 8;
	localparam int TICK_W     = 10;
	localparam int LIMIT_W    = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;
	localparam int MILLI_W    = 16;
	localparam int MINUTE_W   = 16;
	localparam int NUM_LEVELS = 5;

	localparam int unsigned DUTY_STEP     = 5;
	localparam int unsigned STOP_FLOOR    = 15;
	localparam int unsigned MS_PER_MINUTE = 60000;

	localparam logic [LEVEL_W-1:0]  LEVEL_STOP = 3'd0;
	localparam logic [LEVEL_W-1:0]  LEVEL_TOP  = 3'd5;
	localparam logic [MINUTE_W-1:0] MINUTE_MAX = 16'hFFFF;

	localparam logic [NUM_LEVELS-1:0][TARGET_W-1:0] LEVEL_DUTY_RST =
		{8'd255, 8'd200, 8'd140, 8'd100, 8'd60};
	localparam logic [TICK_W-1:0]  STEP_DELAY_RST  = 10'd10;
	localparam logic [LIMIT_W-1:0] FAULT_LIMIT_RST = 10'd100;

	typedef enum logic {
		ACT_SET  = 1'b0,
		ACT_TICK = 1'b1
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LEVEL_ONE   = 3'd0,
		CFG_LEVEL_TWO   = 3'd1,
		CFG_LEVEL_THREE = 3'd2,
		CFG_LEVEL_FOUR  = 3'd3,
		CFG_LEVEL_FIVE  = 3'd4,
		CFG_STEP_DELAY  = 3'd5,
		CFG_FAULT_LIMIT = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [NUM_LEVELS-1:0][TARGET_W-1:0] level_duty;
		logic [TICK_W-1:0]                   step_delay;
		logic [LIMIT_W-1:0]                  fault_limit;
	} cfg_regs_t;

endpackage

// ----- design/pslr_if.sv -----
// ----------------------------------------------------------------------------
// pslr_if
// Valid/ready channels of the PWM speed level ramp block.
// ----------------------------------------------------------------------------
interface pslr_cmd_if #(
	parameter int SENSE_WIDTH = 10
);
	logic                               valid;
	logic                               ready;
	logic                               action;
	logic [pslr_pkg::LEVEL_W-1:0]       level;
	logic [SENSE_WIDTH-1:0]             current_reading;

	modport source (output valid, action, level, current_reading, input ready);
	modport sink (input valid, action, level, current_reading, output ready);
endinterface

interface pslr_res_if #(
	parameter int DUTY_WIDTH = 8
);
	logic                               valid;
	logic                               ready;
	logic [DUTY_WIDTH-1:0]              pwm_duty;
	logic [pslr_pkg::LEVEL_W-1:0]       speed_level;
	logic [pslr_pkg::LEVEL_W-1:0]       max_level;
	logic                               running;
	logic [pslr_pkg::MINUTE_W-1:0]      minutes_on;
	logic                               motor_error;
	logic                               ramp_busy;

	modport source (output valid, pwm_duty, speed_level, max_level, running, minutes_on,
		motor_error, ramp_busy, input ready);
	modport sink (input valid, pwm_duty, speed_level, max_level, running, minutes_on,
		motor_error, ramp_busy, output ready);
endinterface

interface pslr_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pslr_pkg::CFG_IDX_W-1:0]     index;
	logic [pslr_pkg::CFG_DATA_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/pslr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// pslr_cfg_regs
// Configuration register file: level targets, step delay and current limit.
// ----------------------------------------------------------------------------
module pslr_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	pslr_cfg_if.sink             cfg,
	output pslr_pkg::cfg_regs_t  regs
);

	pslr_pkg::cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.level_duty  <= pslr_pkg::LEVEL_DUTY_RST;
			regs_q.step_delay  <= pslr_pkg::STEP_DELAY_RST;
			regs_q.fault_limit <= pslr_pkg::FAULT_LIMIT_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (pslr_pkg::cfg_idx_t'(cfg.index))
				pslr_pkg::CFG_LEVEL_ONE:   regs_q.level_duty[0] <= cfg.data[pslr_pkg::TARGET_W-1:0];
				pslr_pkg::CFG_LEVEL_TWO:   regs_q.level_duty[1] <= cfg.data[pslr_pkg::TARGET_W-1:0];
				pslr_pkg::CFG_LEVEL_THREE: regs_q.level_duty[2] <= cfg.data[pslr_pkg::TARGET_W-1:0];
				pslr_pkg::CFG_LEVEL_FOUR:  regs_q.level_duty[3] <= cfg.data[pslr_pkg::TARGET_W-1:0];
				pslr_pkg::CFG_LEVEL_FIVE:  regs_q.level_duty[4] <= cfg.data[pslr_pkg::TARGET_W-1:0];
				pslr_pkg::CFG_STEP_DELAY:  regs_q.step_delay  <= cfg.data[pslr_pkg::TICK_W-1:0];
				pslr_pkg::CFG_FAULT_LIMIT: regs_q.fault_limit <= cfg.data[pslr_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- design/pslr_engine.sv -----
// ----------------------------------------------------------------------------
// pslr_engine
// Ramp state and its one-item update: level commands, ticks, ramp steps,
// run-time counters and the current check at ramp end.
// ----------------------------------------------------------------------------
module pslr_engine #(
	parameter int DUTY_WIDTH  = 8,
	parameter int SENSE_WIDTH = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pslr_pkg::cfg_regs_t                 regs,
	input  logic                                item_valid,
	input  logic                                action,
	input  logic [pslr_pkg::LEVEL_W-1:0]        level,
	input  logic [SENSE_WIDTH-1:0]              current_reading,
	output logic [DUTY_WIDTH-1:0]               res_duty,
	output logic [pslr_pkg::LEVEL_W-1:0]        res_level,
	output logic [pslr_pkg::LEVEL_W-1:0]        res_peak,
	output logic                                res_running,
	output logic [pslr_pkg::MINUTE_W-1:0]       res_minutes,
	output logic                                res_error,
	output logic                                res_ramp
);

	localparam int CMP_W = (SENSE_WIDTH > pslr_pkg::LIMIT_W) ? SENSE_WIDTH : pslr_pkg::LIMIT_W;
	localparam logic [DUTY_WIDTH:0]   DUTY_MAX_X = {1'b0, {DUTY_WIDTH{1'b1}}};
	localparam logic [DUTY_WIDTH-1:0] STEP_D     = DUTY_WIDTH'(pslr_pkg::DUTY_STEP);
	localparam logic [DUTY_WIDTH-1:0] FLOOR_D    = DUTY_WIDTH'(pslr_pkg::STOP_FLOOR);
	localparam logic [pslr_pkg::MILLI_W-1:0] MS_MIN =
		pslr_pkg::MILLI_W'(pslr_pkg::MS_PER_MINUTE);

	logic [DUTY_WIDTH-1:0]             duty_q, n_duty;
	logic [pslr_pkg::LEVEL_W-1:0]      level_q, n_level;
	logic [pslr_pkg::LEVEL_W-1:0]      peak_q, n_peak;
	logic                              run_q, n_run;
	logic                              ramp_q, n_ramp;
	logic                              stop_q, n_stop;
	logic [DUTY_WIDTH-1:0]             goal_q, n_goal;
	logic [pslr_pkg::TICK_W-1:0]       delay_q, n_delay;
	logic [pslr_pkg::MILLI_W-1:0]      milli_q, n_milli;
	logic [pslr_pkg::MINUTE_W-1:0]     minute_q, n_minute;
	logic                              err;

	always_comb begin
		logic                          do_step;
		logic                          over_limit;
		logic [pslr_pkg::LEVEL_W-1:0]  lvl_idx;
		logic [pslr_pkg::TICK_W:0]     delay_inc;
		logic [pslr_pkg::MILLI_W-1:0]  milli_inc;
		logic [DUTY_WIDTH:0]           up_sum;
		logic [DUTY_WIDTH-1:0]         up_duty;
		logic [DUTY_WIDTH-1:0]         dn_duty;
		logic [DUTY_WIDTH-1:0]         stop_duty;

		n_duty   = duty_q;
		n_level  = level_q;
		n_peak   = peak_q;
		n_run    = run_q;
		n_ramp   = ramp_q;
		n_stop   = stop_q;
		n_goal   = goal_q;
		n_delay  = delay_q;
		n_milli  = milli_q;
		n_minute = minute_q;
		err      = 1'b0;
		do_step  = 1'b0;
		lvl_idx  = level - 3'd1;
		delay_inc = {1'b0, delay_q} + 1'b1;
		milli_inc = milli_q + 1'b1;
		over_limit = CMP_W'(current_reading) > CMP_W'(regs.fault_limit);

		if (item_valid) begin
			if (pslr_pkg::action_t'(action) == pslr_pkg::ACT_SET) begin
				// A start from standstill restarts the run-time clock.
				if (level != pslr_pkg::LEVEL_STOP && !run_q) begin
					n_milli  = '0;
					n_minute = '0;
				end
				if (level > peak_q)
					n_peak = level;
				if (level <= pslr_pkg::LEVEL_TOP) begin
					n_level = level;
					n_delay = '0;
					n_ramp  = 1'b1;
					do_step = 1'b1;
					if (level == pslr_pkg::LEVEL_STOP) begin
						n_run  = 1'b0;
						n_stop = 1'b1;
					end else begin
						n_run  = 1'b1;
						n_stop = 1'b0;
						n_goal = DUTY_WIDTH'(regs.level_duty[lvl_idx]);
					end
				end
			end else begin
				if (milli_inc >= MS_MIN) begin
					n_milli = '0;
					if (minute_q < pslr_pkg::MINUTE_MAX)
						n_minute = minute_q + 1'b1;
				end else begin
					n_milli = milli_inc;
				end
				if (ramp_q) begin
					if (delay_inc >= {1'b0, regs.step_delay}) begin
						n_delay = '0;
						do_step = 1'b1;
					end else begin
						n_delay = delay_inc[pslr_pkg::TICK_W-1:0];
					end
				end
			end
		end

		up_sum    = {1'b0, duty_q} + {1'b0, STEP_D};
		up_duty   = (up_sum > DUTY_MAX_X) ? DUTY_MAX_X[DUTY_WIDTH-1:0] : up_sum[DUTY_WIDTH-1:0];
		dn_duty   = (duty_q >= STEP_D) ? duty_q - STEP_D : '0;
		stop_duty = (duty_q > FLOOR_D) ? duty_q - STEP_D : duty_q;

		if (do_step) begin
			if (n_stop) begin
				// Soft stop: once at or below the floor the output is cut to zero.
				n_duty = stop_duty;
				if (stop_duty <= FLOOR_D) begin
					n_duty = '0;
					n_ramp = 1'b0;
					n_stop = 1'b0;
				end
			end else if (duty_q < n_goal) begin
				n_duty = up_duty;
				if (up_duty >= n_goal) begin
					n_ramp = 1'b0;
					err    = over_limit;
				end
			end else if (duty_q > n_goal && n_level != pslr_pkg::LEVEL_TOP) begin
				n_duty = dn_duty;
				if (dn_duty == n_goal) begin
					n_ramp = 1'b0;
					err    = over_limit;
				end
			end else begin
				n_ramp = 1'b0;
				err    = over_limit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q   <= '0;
			level_q  <= '0;
			peak_q   <= '0;
			run_q    <= 1'b0;
			ramp_q   <= 1'b0;
			stop_q   <= 1'b0;
			goal_q   <= '0;
			delay_q  <= '0;
			milli_q  <= '0;
			minute_q <= '0;
		end else if (item_valid) begin
			duty_q   <= n_duty;
			level_q  <= n_level;
			peak_q   <= n_peak;
			run_q    <= n_run;
			ramp_q   <= n_ramp;
			stop_q   <= n_stop;
			goal_q   <= n_goal;
			delay_q  <= n_delay;
			milli_q  <= n_milli;
			minute_q <= n_minute;
		end
	end

	assign res_duty    = n_duty;
	assign res_level   = n_level;
	assign res_peak    = n_peak;
	assign res_running = n_run;
	assign res_minutes = n_run ? n_minute : '0;
	assign res_error   = err;
	assign res_ramp    = n_ramp;

endmodule

// ----- design/pwm_speed_level_ramp_core.sv -----
// Path: an accepted item passes the input register, then the state update
// into the result register.
// Throughput: one item per cycle; the input side stalls only when the
// result register holds an untaken result and an item waits behind it.
// Reset: arst_n clears all ramp and counter state and loads the default
// configuration; no clearing pass, items are taken right after reset.
// ----------------------------------------------------------------------------
// pwm_speed_level_ramp_core
// PWM soft start/stop ramp driven by speed level commands and 1 ms ticks.
// ----------------------------------------------------------------------------
module pwm_speed_level_ramp_core #(
	parameter int DUTY_WIDTH  = 8,
	parameter int SENSE_WIDTH = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	pslr_cmd_if.sink   cmd,
	pslr_res_if.source result,
	pslr_cfg_if.sink   cfg
);

	pslr_pkg::cfg_regs_t              regs;

	logic                             vld_s1;
	logic                             action_s1;
	logic [pslr_pkg::LEVEL_W-1:0]     level_s1;
	logic [SENSE_WIDTH-1:0]           cur_s1;

	logic                             vld_s2;
	logic [DUTY_WIDTH-1:0]            duty_s2;
	logic [pslr_pkg::LEVEL_W-1:0]     level_s2;
	logic [pslr_pkg::LEVEL_W-1:0]     peak_s2;
	logic                             run_s2;
	logic [pslr_pkg::MINUTE_W-1:0]    minutes_s2;
	logic                             err_s2;
	logic                             ramp_s2;

	logic [DUTY_WIDTH-1:0]            res_duty;
	logic [pslr_pkg::LEVEL_W-1:0]     res_level;
	logic [pslr_pkg::LEVEL_W-1:0]     res_peak;
	logic                             res_running;
	logic [pslr_pkg::MINUTE_W-1:0]    res_minutes;
	logic                             res_error;
	logic                             res_ramp;

	logic                             advance;
	logic                             cmd_fire;

	// The registered item moves on whenever the result slot is free or being emptied.
	assign advance   = vld_s1 && (!vld_s2 || result.ready);
	assign cmd.ready = !vld_s1 || advance;
	assign cmd_fire  = cmd.valid && cmd.ready;

	pslr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pslr_engine #(
		.DUTY_WIDTH  (DUTY_WIDTH),
		.SENSE_WIDTH (SENSE_WIDTH)
	) u_engine (
		.clk             (clk),
		.arst_n          (arst_n),
		.regs            (regs),
		.item_valid      (advance),
		.action          (action_s1),
		.level           (level_s1),
		.current_reading (cur_s1),
		.res_duty        (res_duty),
		.res_level       (res_level),
		.res_peak        (res_peak),
		.res_running     (res_running),
		.res_minutes     (res_minutes),
		.res_error       (res_error),
		.res_ramp        (res_ramp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd_fire)
				vld_s1 <= 1'b1;
			else if (advance)
				vld_s1 <= 1'b0;
			if (advance)
				vld_s2 <= 1'b1;
			else if (result.ready)
				vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			action_s1 <= cmd.action;
			level_s1  <= cmd.level;
			cur_s1    <= cmd.current_reading;
		end
		if (advance) begin
			duty_s2    <= res_duty;
			level_s2   <= res_level;
			peak_s2    <= res_peak;
			run_s2     <= res_running;
			minutes_s2 <= res_minutes;
			err_s2     <= res_error;
			ramp_s2    <= res_ramp;
		end
	end

	assign result.valid       = vld_s2;
	assign result.pwm_duty    = duty_s2;
	assign result.speed_level = level_s2;
	assign result.max_level   = peak_s2;
	assign result.running     = run_s2;
	assign result.minutes_on  = minutes_s2;
	assign result.motor_error = err_s2;
	assign result.ramp_busy   = ramp_s2;

endmodule

// ----- design/pslr_checker.sv -----
// ----------------------------------------------------------------------------
// pslr_checker
// Port-level checks of the PWM speed level ramp block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pslr_checker #(
	parameter int DUTY_WIDTH = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             out_valid,
	input  logic                             out_ready,
	input  logic [DUTY_WIDTH-1:0]            out_duty,
	input  logic [pslr_pkg::LEVEL_W-1:0]     out_level,
	input  logic [pslr_pkg::LEVEL_W-1:0]     out_peak,
	input  logic                             out_running,
	input  logic [pslr_pkg::MINUTE_W-1:0]    out_minutes,
	input  logic                             out_error,
	input  logic                             out_ramp
);

	// A stalled result stays valid and keeps its duty.
	`PSLR_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_duty))

	// The motor runs exactly when a nonzero level is selected.
	`PSLR_ASSERT_MSG(a_run_level, out_valid |-> (out_running == (out_level != pslr_pkg::LEVEL_STOP)), "run flag mismatch")

	// The minute count reads zero while stopped.
	`PSLR_ASSERT(a_minutes_idle, out_valid && !out_running |-> out_minutes == '0)

	// A current fault is reported only when a ramp has just finished.
	`PSLR_ASSERT_MSG(a_err_end, out_valid && out_error |-> !out_ramp, "fault while ramping")

	// The recorded peak never falls below the active level.
	`PSLR_ASSERT(a_peak, out_valid |-> out_peak >= out_level)

endmodule

bind pwm_speed_level_ramp_core pslr_checker #(
	.DUTY_WIDTH (DUTY_WIDTH)
) u_pslr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_duty    (result.pwm_duty),
	.out_level   (result.speed_level),
	.out_peak    (result.max_level),
	.out_running (result.running),
	.out_minutes (result.minutes_on),
	.out_error   (result.motor_error),
	.out_ramp    (result.ramp_busy)
);
